// ----- src/bbb_pkg.sv -----
// ----------------------------------------------------------------------------
// bbb_pkg
// Shared types, constants and helpers of the bi-objective box bound core.
// ----------------------------------------------------------------------------
package bbb_pkg;

    localparam int COST_BITS      = 16;
    localparam int IDX_BITS       = 8;
    localparam int SUM_BITS       = 40;
    localparam int BASE_BITS      = 32;
    localparam int CNT_BITS       = 11;
    localparam int MAX_FACILITIES = 256;
    localparam int MAX_CUSTOMERS  = 1024;
    localparam int COUNT_MAX      = (MAX_CUSTOMERS < 2047) ? MAX_CUSTOMERS : 2047;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam int S_TDATA_BITS = 40;
    localparam int S_TUSER_BITS = 3;
    localparam int M_TDATA_BITS = 256;
    localparam int M_TUSER_BITS = 3;

    localparam int CFG_ADDR_BITS = 1;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_BASE_COST_ONE = 1'b0,
        REG_BASE_COST_TWO = 1'b1
    } cfg_reg_t;

    // per-customer work handed from front to back
    typedef struct packed {
        logic                 reload;
        logic                 emit;
        logic                 none_open;
        logic                 assigned;
        logic                 last_cust;
        logic [COST_BITS-1:0] first_primary;
        logic [COST_BITS-1:0] first_secondary;
        logic [COST_BITS-1:0] second_primary;
        logic [COST_BITS-1:0] second_secondary;
    } cmd_t;

    typedef struct packed {
        logic [SUM_BITS-1:0] min_one;
        logic [SUM_BITS-1:0] min_two;
        logic [SUM_BITS-1:0] max_one;
        logic [SUM_BITS-1:0] max_two;
        logic [SUM_BITS-1:0] origin_one;
        logic [SUM_BITS-1:0] origin_two;
    } sums_t;

    typedef struct packed {
        logic                customer_assigned;
        logic                no_open_facility;
        logic                more_steps;
        logic                box_done;
        sums_t               sums;
        logic [CNT_BITS-1:0] unassigned_count;
    } result_t;

    function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0]  a,
                                                    input logic [COST_BITS-1:0] b);
        logic [SUM_BITS:0] s;
        s = {1'b0, a} + (SUM_BITS+1)'(b);
        return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
    endfunction

endpackage

// ----- src/bbb_front.sv -----
// ----------------------------------------------------------------------------
// bbb_front
// Tracks both lexicographic minima over a customer's open facilities and
// issues one command per customer end or box start.
// ----------------------------------------------------------------------------
module bbb_front
    import bbb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic                 new_box,
    input  logic [IDX_BITS-1:0]  facility_index,
    input  logic                 facility_open,
    input  logic [COST_BITS-1:0] alloc_cost_one,
    input  logic [COST_BITS-1:0] alloc_cost_two,
    input  logic                 last_facility,
    input  logic                 last_customer,
    output logic                 cmd_push,
    output cmd_t                 cmd
);

    logic [COST_BITS-1:0] fp_reg, fp_next, fs_reg, fs_next;
    logic [COST_BITS-1:0] sp_reg, sp_next, ss_reg, ss_next;
    logic [IDX_BITS-1:0]  fi_reg, fi_next, si_reg, si_next;
    logic                 any_reg, any_next;
    logic                 any_eff, is_open, better_one, better_two, any_seen;

    always_comb begin
        any_eff    = any_reg && !new_box;
        is_open    = facility_open && ({1'b0, facility_index} < (IDX_BITS+1)'(MAX_FACILITIES));
        better_one = !any_eff || (alloc_cost_one < fp_reg) ||
                     (alloc_cost_one == fp_reg && alloc_cost_two < fs_reg);
        better_two = !any_eff || (alloc_cost_two < sp_reg) ||
                     (alloc_cost_two == sp_reg && alloc_cost_one < ss_reg);
        fp_next = fp_reg;
        fs_next = fs_reg;
        fi_next = fi_reg;
        sp_next = sp_reg;
        ss_next = ss_reg;
        si_next = si_reg;
        if (is_open && better_one) begin
            fp_next = alloc_cost_one;
            fs_next = alloc_cost_two;
            fi_next = facility_index;
        end
        if (is_open && better_two) begin
            sp_next = alloc_cost_two;
            ss_next = alloc_cost_one;
            si_next = facility_index;
        end
        any_seen = any_eff || is_open;
        any_next = last_facility ? 1'b0 : any_seen;
    end

    always_comb begin
        cmd_push             = accept && (new_box || last_facility);
        cmd.reload           = new_box;
        cmd.emit             = last_facility;
        cmd.none_open        = !any_seen;
        cmd.assigned         = any_seen && (fi_next == si_next);
        cmd.last_cust        = last_customer;
        cmd.first_primary    = fp_next;
        cmd.first_secondary  = fs_next;
        cmd.second_primary   = sp_next;
        cmd.second_secondary = ss_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_reg <= 1'b0;
            fp_reg  <= '0;
            fs_reg  <= '0;
            fi_reg  <= '0;
            sp_reg  <= '0;
            ss_reg  <= '0;
            si_reg  <= '0;
        end else if (accept) begin
            any_reg <= any_next;
            fp_reg  <= fp_next;
            fs_reg  <= fs_next;
            fi_reg  <= fi_next;
            sp_reg  <= sp_next;
            ss_reg  <= ss_next;
            si_reg  <= si_next;
        end
    end

endmodule

// ----- src/bbb_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// bbb_cmd_queue
// Short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module bbb_cmd_queue
    import bbb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t                 mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    always_comb begin
        full        = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
        head_valid  = (count_reg != '0);
        head_cmd    = mem[rd_ptr_reg];
        do_push     = push && !full;
        do_pop      = pop && head_valid;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/bbb_back.sv -----
// ----------------------------------------------------------------------------
// bbb_back
// Carries out commands: reloads and accumulates the six saturating sums and
// the unassigned count, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module bbb_back
    import bbb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [BASE_BITS-1:0] base_cost_one,
    input  logic [BASE_BITS-1:0] base_cost_two,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    output logic                 cmd_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output result_t              out_result
);

    sums_t               sums_reg, sums_next, start;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next, cnt_start;
    logic                valid_reg, valid_next;
    result_t             res_reg, res_next;
    logic [COST_BITS-1:0] add_min_two, add_max_one;

    always_comb begin
        cmd_pop = cmd_valid && (!valid_reg || out_ready);

        if (cmd.reload) begin
            start.min_one    = SUM_BITS'(base_cost_one);
            start.max_one    = SUM_BITS'(base_cost_one);
            start.origin_one = SUM_BITS'(base_cost_one);
            start.min_two    = SUM_BITS'(base_cost_two);
            start.max_two    = SUM_BITS'(base_cost_two);
            start.origin_two = SUM_BITS'(base_cost_two);
            cnt_start        = '0;
        end else begin
            start     = sums_reg;
            cnt_start = cnt_reg;
        end

        add_min_two = cmd.assigned ? cmd.first_secondary : cmd.second_primary;
        add_max_one = cmd.assigned ? cmd.first_primary : cmd.second_secondary;

        sums_next = start;
        cnt_next  = cnt_start;
        if (cmd.emit && !cmd.none_open) begin
            sums_next.min_one = sat_add(start.min_one, cmd.first_primary);
            sums_next.min_two = sat_add(start.min_two, add_min_two);
            sums_next.max_one = sat_add(start.max_one, add_max_one);
            sums_next.max_two = sat_add(start.max_two, cmd.first_secondary);
        end
        if (cmd.emit && cmd.assigned) begin
            sums_next.origin_one = sat_add(start.origin_one, cmd.first_primary);
            sums_next.origin_two = sat_add(start.origin_two, cmd.first_secondary);
        end
        if (cmd.emit && !cmd.assigned && cnt_start < CNT_BITS'(COUNT_MAX)) begin
            cnt_next = cnt_start + 1'b1;
        end

        res_next.customer_assigned = cmd.assigned;
        res_next.no_open_facility  = cmd.none_open;
        res_next.more_steps        = cmd.last_cust && (cnt_next != '0);
        res_next.box_done          = cmd.last_cust;
        res_next.sums              = sums_next;
        res_next.unassigned_count  = cnt_next;

        if (cmd_pop && cmd.emit) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sums_reg  <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cmd_pop) begin
                sums_reg <= sums_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop && cmd.emit) begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = res_reg;

endmodule

// ----- src/biobjective_box_bound_core.sv -----
// ----------------------------------------------------------------------------
// biobjective_box_bound_core
// Bi-objective lower and upper bound of a facility box, one cost pair a beat.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata, s_tuser, s_tlast (cost pair)
//  m_      | out | m_tvalid/m_tready  | m_tdata, m_tuser, m_tlast (customer result)
//  cfg_    | in  | cfg_wr_en          | cfg_addr, cfg_wr_data (base costs)
//
// one input beat per cycle unless the command queue is full; results leave via the back's register
// the front updates both minima in the accept cycle, the back adds into the sums
// a four-entry command queue lets the front run on while the result port stalls
// synchronous active-low reset clears all sums, counts and the base registers
// ----------------------------------------------------------------------------
module biobjective_box_bound_core
    import bbb_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [BASE_BITS-1:0]     cfg_wr_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // facility_index, alloc_cost_one, alloc_cost_two
    input  logic [S_TDATA_BITS-1:0]  s_tdata,
    // new_box, facility_open, last_customer
    input  logic [S_TUSER_BITS-1:0]  s_tuser,
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // sum_min_one, sum_min_two, sum_max_one, sum_max_two, sum_origin_one,
    // sum_origin_two, unassigned_count, zero pad
    output logic [M_TDATA_BITS-1:0]  m_tdata,
    // customer_assigned, no_open_facility, more_steps
    output logic [M_TUSER_BITS-1:0]  m_tuser,
    output logic                     m_tlast
);

    logic [BASE_BITS-1:0] base_one_reg, base_two_reg;
    logic                 q_full, q_push, q_pop, q_valid, accept;
    cmd_t                 push_cmd, head_cmd;
    result_t              res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_one_reg <= '0;
            base_two_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BASE_COST_ONE: base_one_reg <= cfg_wr_data;
                REG_BASE_COST_TWO: base_two_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    bbb_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .new_box        (s_tuser[0]),
        .facility_index (s_tdata[7:0]),
        .facility_open  (s_tuser[1]),
        .alloc_cost_one (s_tdata[23:8]),
        .alloc_cost_two (s_tdata[39:24]),
        .last_facility  (s_tlast),
        .last_customer  (s_tuser[2]),
        .cmd_push       (q_push),
        .cmd            (push_cmd)
    );

    bbb_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    bbb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .base_cost_one (base_one_reg),
        .base_cost_two (base_two_reg),
        .cmd_valid     (q_valid),
        .cmd           (head_cmd),
        .cmd_pop       (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_result    (res)
    );

    assign m_tdata = {5'b0, res.unassigned_count,
                      res.sums.origin_two, res.sums.origin_one,
                      res.sums.max_two, res.sums.max_one,
                      res.sums.min_two, res.sums.min_one};
    assign m_tuser = {res.more_steps, res.no_open_facility, res.customer_assigned};
    assign m_tlast = res.box_done;

endmodule

// ----- src/bbb_checker.sv -----
// ----------------------------------------------------------------------------
// bbb_checker
// Port-level checks of the bi-objective box bound core, bound to the top.
// ----------------------------------------------------------------------------
module bbb_checker
    import bbb_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata,
    input logic [M_TUSER_BITS-1:0] m_tuser,
    input logic                    m_tlast
);

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("assigned customer flagged with no open facility");

    a_more: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tlast)
        else $error("more_steps outside the last customer");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1] || m_tuser[2]) |-> m_tdata[250:240] != '0)
        else $error("unassigned count zero where a customer is unassigned");

endmodule

bind biobjective_box_bound_core bbb_checker u_bbb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- dv/biobjective_box_bound_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biobjective_box_bound_core_tb
// Self-checking bench for the box bound core. A directed table covers reset
// state, extreme costs and base values, ties, repeated facilities, a stray
// last-customer flag and a box restart mid-customer. Then one long box runs
// the unassigned count into saturation, and random boxes follow with random
// base values. Every beat is scored by a model of the bound sums, and each
// result beat is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module biobjective_box_bound_core_tb;
    import bbb_pkg::*;

    localparam int RANDOM_BEATS = 200;
    localparam int CALM_BEATS   = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam bit [SUM_BITS-1:0] SUM_TOP = '1;

    typedef struct packed {
        bit                   new_box;
        bit [IDX_BITS-1:0]    index;
        bit                   open;
        bit [COST_BITS-1:0]   cost_one;
        bit [COST_BITS-1:0]   cost_two;
        bit                   last_fac;
        bit                   last_cust;
    } cost_beat_t;

    typedef struct packed {
        logic                          assigned;
        logic                          none_open;
        logic [5:0][SUM_BITS-1:0]      sums;
        logic [CNT_BITS-1:0]           count;
        logic                          more;
        logic                          done;
    } customer_res_t;

    typedef struct {
        bit            is_write;
        cfg_reg_t      reg_sel;
        bit [31:0]     reg_val;
        cost_beat_t    b;
        bit            typed;
        customer_res_t want;
    } plan_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [BASE_BITS-1:0]     cfg_wr_data = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // facility_index, alloc_cost_one, alloc_cost_two
    logic [S_TDATA_BITS-1:0]  s_tdata = '0;
    // new_box, facility_open, last_customer
    logic [S_TUSER_BITS-1:0]  s_tuser = '0;
    logic                     s_tlast = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // sum_min_one, sum_min_two, sum_max_one, sum_max_two, sum_origin_one,
    // sum_origin_two, unassigned_count, zero pad
    logic [M_TDATA_BITS-1:0]  m_tdata;
    // customer_assigned, no_open_facility, more_steps
    logic [M_TUSER_BITS-1:0]  m_tuser;
    logic                     m_tlast;

    biobjective_box_bound_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // bound model state
    bit [31:0]          base_one, base_two;
    bit [COST_BITS-1:0] lex1_primary, lex1_secondary, lex2_primary, lex2_secondary;
    bit [IDX_BITS-1:0]  lex1_index, lex2_index;
    bit                 open_seen;
    bit [SUM_BITS-1:0]  bound_sum [6];
    int                 unassigned;

    customer_res_t pending_outcomes [$];
    plan_row_t     plan [$];
    int            mismatches = 0;
    int            beats_sent = 0;
    bit            send_idle = 1'b0;
    bit            ready_idle = 1'b0;
    bit            calm = 1'b0;
    int            stall_left = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("biobjective_box_bound_core verification failed");
        $finish;
    end

    function automatic bit [SUM_BITS-1:0] clamp_add(input bit [SUM_BITS-1:0] a,
                                                    input bit [COST_BITS-1:0] c);
        return (a > SUM_TOP - SUM_BITS'(c)) ? SUM_TOP : a + SUM_BITS'(c);
    endfunction

    function automatic void count_unassigned();
        if (unassigned < COUNT_MAX) unassigned++;
    endfunction

    function automatic bit tally_beat(input cost_beat_t b, output customer_res_t r);
        bit open_ok;
        r = '0;
        open_ok = b.open && (int'(b.index) < MAX_FACILITIES);
        if (b.new_box) begin
            for (int k = 0; k < 6; k += 2) begin
                bound_sum[k]     = SUM_BITS'(base_one);
                bound_sum[k + 1] = SUM_BITS'(base_two);
            end
            unassigned = 0;
            open_seen = 1'b0;
        end
        if (open_ok) begin
            if (!open_seen || b.cost_one < lex1_primary ||
                (b.cost_one == lex1_primary && b.cost_two < lex1_secondary)) begin
                lex1_primary   = b.cost_one;
                lex1_secondary = b.cost_two;
                lex1_index     = b.index;
            end
            if (!open_seen || b.cost_two < lex2_primary ||
                (b.cost_two == lex2_primary && b.cost_one < lex2_secondary)) begin
                lex2_primary   = b.cost_two;
                lex2_secondary = b.cost_one;
                lex2_index     = b.index;
            end
            open_seen = 1'b1;
        end
        if (!b.last_fac) return 1'b0;
        r.none_open = !open_seen;
        if (!open_seen) begin
            count_unassigned();
        end else if (lex1_index == lex2_index) begin
            r.assigned = 1'b1;
            for (int k = 0; k < 6; k += 2) begin
                bound_sum[k]     = clamp_add(bound_sum[k], lex1_primary);
                bound_sum[k + 1] = clamp_add(bound_sum[k + 1], lex1_secondary);
            end
        end else begin
            bound_sum[0] = clamp_add(bound_sum[0], lex1_primary);
            bound_sum[1] = clamp_add(bound_sum[1], lex2_primary);
            bound_sum[2] = clamp_add(bound_sum[2], lex2_secondary);
            bound_sum[3] = clamp_add(bound_sum[3], lex1_secondary);
            count_unassigned();
        end
        open_seen = 1'b0;
        for (int k = 0; k < 6; k++) r.sums[k] = bound_sum[k];
        r.count = CNT_BITS'(unassigned);
        r.more  = b.last_cust && (unassigned != 0);
        r.done  = b.last_cust;
        return 1'b1;
    endfunction

    function automatic void add_beat(input bit nb, input bit [7:0] idx, input bit op,
                                     input bit [15:0] c1, input bit [15:0] c2,
                                     input bit lf, input bit lc);
        plan_row_t row;
        row.is_write = 1'b0;
        row.reg_sel  = REG_BASE_COST_ONE;
        row.reg_val  = '0;
        row.typed    = 1'b0;
        row.want     = '0;
        row.b = '{new_box: nb, index: idx, open: op, cost_one: c1, cost_two: c2,
                  last_fac: lf, last_cust: lc};
        plan.push_back(row);
    endfunction

    function automatic void add_write(input cfg_reg_t sel, input bit [31:0] val);
        plan_row_t row;
        row.b        = '0;
        row.typed    = 1'b0;
        row.want     = '0;
        row.is_write = 1'b1;
        row.reg_sel  = sel;
        row.reg_val  = val;
        plan.push_back(row);
    endfunction

    function automatic void add_known(input bit asg, input bit none,
                                      input bit [SUM_BITS-1:0] s_one,
                                      input bit [SUM_BITS-1:0] s_two,
                                      input bit [CNT_BITS-1:0] cnt, input bit more);
        int last;
        last = plan.size() - 1;
        plan[last].typed          = 1'b1;
        plan[last].want.assigned  = asg;
        plan[last].want.none_open = none;
        for (int k = 0; k < 6; k += 2) begin
            plan[last].want.sums[k]     = s_one;
            plan[last].want.sums[k + 1] = s_two;
        end
        plan[last].want.count = cnt;
        plan[last].want.more  = more;
        plan[last].want.done  = plan[last].b.last_cust;
    endfunction

    function automatic bit [COST_BITS-1:0] pick_cost(input int mode);
        case (mode)
            0: return COST_BITS'($urandom_range(0, 3));
            1: return COST_BITS'($urandom);
            default: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return COST_BITS'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic bit [31:0] pick_base();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input cost_beat_t b, input bit typed, input customer_res_t want);
        customer_res_t r;
        if (send_idle && !calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b.cost_two, b.cost_one, b.index};
        s_tuser  <= {b.last_cust, b.open, b.new_box};
        s_tlast  <= b.last_fac;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (tally_beat(b, r)) pending_outcomes.push_back(typed ? want : r);
        beats_sent++;
    endtask

    task automatic drain(input int tail);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input bit [31:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= sel;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (sel)
            REG_BASE_COST_ONE: base_one = val;
            REG_BASE_COST_TWO: base_two = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_customer(input bit opens_box, input bit closes_box);
        cost_beat_t b;
        int n;
        int mode;
        bit [IDX_BITS-1:0] prev;
        n = $urandom_range(1, 6);
        mode = $urandom_range(0, 2);
        prev = IDX_BITS'($urandom);
        for (int i = 0; i < n; i++) begin
            b.new_box   = (opens_box && i == 0) || ($urandom_range(0, 39) == 0);
            b.index     = (i != 0 && $urandom_range(0, 5) == 0) ? prev : IDX_BITS'($urandom);
            prev        = b.index;
            b.open      = $urandom_range(0, 4) != 0;
            b.cost_one  = pick_cost(mode);
            b.cost_two  = pick_cost(mode);
            b.last_fac  = (i == n - 1) && ($urandom_range(0, 19) != 0);
            b.last_cust = (closes_box && i == n - 1) || ($urandom_range(0, 29) == 0);
            send_beat(b, 1'b0, '0);
        end
    endtask

    task automatic send_noise();
        cost_beat_t b;
        b.new_box   = 1'($urandom);
        b.index     = IDX_BITS'($urandom);
        b.open      = 1'($urandom);
        b.cost_one  = COST_BITS'($urandom);
        b.cost_two  = COST_BITS'($urandom);
        b.last_fac  = 1'($urandom);
        b.last_cust = 1'($urandom);
        send_beat(b, 1'b0, '0);
    endtask

    // one box with more unassigned customers than the count holds
    task automatic saturate_count();
        cost_beat_t b;
        for (int k = 0; k < COUNT_MAX + 100; k++) begin
            b.new_box   = (k == 0);
            b.index     = IDX_BITS'($urandom);
            b.open      = (k % 16 == 5);
            b.cost_one  = COST_BITS'($urandom);
            b.cost_two  = COST_BITS'($urandom);
            b.last_fac  = 1'b1;
            b.last_cust = (k == COUNT_MAX + 99);
            send_beat(b, 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (ready_idle && !calm && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void note_field(input string name, input logic [SUM_BITS-1:0] want,
                                       input logic [SUM_BITS-1:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        customer_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.assigned  = m_tuser[0];
            got.none_open = m_tuser[1];
            got.more      = m_tuser[2];
            got.done      = m_tlast;
            for (int k = 0; k < 6; k++) got.sums[k] = m_tdata[k*SUM_BITS +: SUM_BITS];
            got.count = m_tdata[6*SUM_BITS +: CNT_BITS];
            if (pending_outcomes.size() == 0) begin
                if (mismatches < 10) $display("result beat with nothing expected");
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                note_field("customer_assigned", SUM_BITS'(want.assigned), SUM_BITS'(got.assigned));
                note_field("no_open_facility", SUM_BITS'(want.none_open), SUM_BITS'(got.none_open));
                note_field("sum_min_one", want.sums[0], got.sums[0]);
                note_field("sum_min_two", want.sums[1], got.sums[1]);
                note_field("sum_max_one", want.sums[2], got.sums[2]);
                note_field("sum_max_two", want.sums[3], got.sums[3]);
                note_field("sum_origin_one", want.sums[4], got.sums[4]);
                note_field("sum_origin_two", want.sums[5], got.sums[5]);
                note_field("unassigned_count", SUM_BITS'(want.count), SUM_BITS'(got.count));
                note_field("more_steps", SUM_BITS'(want.more), SUM_BITS'(got.more));
                note_field("box_done", SUM_BITS'(want.done), SUM_BITS'(got.done));
            end
        end
    end

    initial begin : stimulus
        int rand_from;
        int phase;
        int nbox;
        int ncust;

        // sums start at zero out of reset, bases not yet loaded
        add_beat(0, 8'h00, 0, 16'hFFFF, 16'hFFFF, 1, 0);
        add_known(0, 1, '0, '0, 1, 0);
        add_beat(0, 8'hFF, 1, 16'hFFFF, 16'hFFFF, 1, 1);
        add_known(1, 0, 40'hFFFF, 40'hFFFF, 1, 1);
        add_write(REG_BASE_COST_ONE, 32'hFFFF_FFFF);
        add_write(REG_BASE_COST_TWO, 32'h0000_0000);
        add_beat(1, 8'h00, 1, 16'h0000, 16'h0000, 1, 0);
        add_known(1, 0, 40'hFF_FFFF_FFFF & 40'hFFFF_FFFF, '0, 0, 0);
        add_beat(1, 8'h03, 1, 16'h0007, 16'h0007, 1, 1);
        add_known(1, 0, 40'h1_0000_0006, 40'h7, 0, 0);
        add_beat(1, 8'h80, 0, 16'hFFFF, 16'hFFFF, 1, 1);
        add_known(0, 1, 40'hFFFF_FFFF, '0, 1, 1);
        add_write(REG_BASE_COST_ONE, 32'h0000_0000);
        add_write(REG_BASE_COST_TWO, 32'hFFFF_FFFF);
        // minima on different facilities
        add_beat(1, 8'h03, 1, 16'd10, 16'd50, 0, 0);
        add_beat(0, 8'h07, 1, 16'd40, 16'd5, 1, 0);
        // equal pair does not replace the held minimum
        add_beat(0, 8'h01, 1, 16'd20, 16'd20, 0, 0);
        add_beat(0, 8'h02, 1, 16'd20, 16'd20, 1, 0);
        // tie on the primary cost, broken by the secondary
        add_beat(0, 8'h04, 1, 16'd5, 16'd9, 0, 0);
        add_beat(0, 8'h05, 1, 16'd5, 16'd3, 1, 0);
        // one facility index seen twice
        add_beat(0, 8'h09, 1, 16'd10, 16'd50, 0, 0);
        add_beat(0, 8'h09, 1, 16'd50, 16'd10, 1, 0);
        // last customer flag without last facility
        add_beat(0, 8'h08, 1, 16'd1, 16'd1, 0, 1);
        add_beat(0, 8'h06, 1, 16'd2, 16'd2, 1, 0);
        // new box in the middle of a customer
        add_beat(0, 8'h01, 1, 16'd3, 16'd3, 0, 0);
        add_beat(1, 8'h02, 0, 16'd0, 16'd0, 1, 0);
        add_beat(0, 8'hAA, 1, 16'hFFFF, 16'h0000, 0, 0);
        add_beat(0, 8'h55, 1, 16'h0000, 16'hFFFF, 0, 0);
        add_beat(0, 8'h00, 0, 16'h0000, 16'h0000, 1, 1);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                drain(SETTLE_CYCLES);
                write_reg(plan[i].reg_sel, plan[i].reg_val);
            end else begin
                send_beat(plan[i].b, plan[i].typed, plan[i].want);
            end
        end

        drain(SETTLE_CYCLES);
        write_reg(REG_BASE_COST_ONE, $urandom);
        write_reg(REG_BASE_COST_TWO, $urandom);
        send_idle  = 1'b1;
        ready_idle = 1'b1;
        saturate_count();

        rand_from = beats_sent;
        phase = 0;
        while (beats_sent - rand_from < RANDOM_BEATS) begin
            calm = (beats_sent - rand_from) >= RANDOM_BEATS - CALM_BEATS;
            drain(SETTLE_CYCLES);
            write_reg(REG_BASE_COST_ONE, pick_base());
            write_reg(REG_BASE_COST_TWO, pick_base());
            send_idle  = $urandom_range(0, 3) != 0;
            ready_idle = $urandom_range(0, 3) != 0;
            nbox = $urandom_range(1, 4);
            for (int bx = 0; bx < nbox; bx++) begin
                ncust = $urandom_range(1, 10);
                for (int c = 0; c < ncust; c++) begin
                    send_customer(c == 0, c == ncust - 1);
                    if ($urandom_range(0, 9) == 0) send_noise();
                end
                // sender holds off until the result side has caught up
                if (bx == 0 && (phase == 2 || $urandom_range(0, 3) == 0)) drain(0);
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("biobjective_box_bound_core verification clean");
        end else begin
            $display("biobjective_box_bound_core verification failed");
        end
        $finish;
    end

endmodule
